// ===== hw/rtl/led_matrix_scan_display_assert.svh =====
// assertion macros for the port-level checker of the led matrix scan display
// no dependencies
`ifndef LED_MATRIX_SCAN_DISPLAY_ASSERT_SVH
`define LED_MATRIX_SCAN_DISPLAY_ASSERT_SVH

// clocked assertion, switched off while reset is held
`define LMSD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// clocked assertion that also checks through reset
`define LMSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/lmsd_pkg.sv =====
// shared types, codes and the seven-segment table of the led matrix scan display
// no dependencies
`default_nettype none

package lmsd_pkg;

    typedef enum logic [2:0] {
        MODE_TICK   = 3'd0,
        MODE_CHARGE = 3'd1,
        MODE_ENERGY = 3'd2,
        MODE_GUN    = 3'd3,
        MODE_LED    = 3'd4,
        MODE_BAR    = 3'd5,
        MODE_CLEAR  = 3'd6,
        MODE_ERROR  = 3'd7
    } mode_t;

    localparam logic [1:0] GUN_NONE   = 2'd3;
    localparam logic [9:0] CHARGE_MAX = 10'd100;
    localparam logic [9:0] ENERGY_MAX = 10'd999;
    localparam logic [4:0] BAR_FULL   = 5'h1F;

    // result of the decimal split unit
    typedef struct packed {
        logic       done;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } digits_t;

    // segments a..g in bits 0..6
    function automatic logic [6:0] seg_of(input logic [3:0] d);
        logic [6:0] s;
        unique case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/led_matrix_scan_display.sv =====
// sequence: a tick or rejected command goes idle -> fetch -> out -> result register;
// row-writing commands sweep all 8 rows with a read and a modify state per row, and
// digit and bar commands first run the shared subtract unit
// flow: one transaction at a time, next input taken once the result is registered
// reset: synchronous active-low aresetn clears frame (row valid bits), scan row,
// error flag, sequencer and m_valid
`default_nettype none

module led_matrix_scan_display (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire logic [2:0]  s_mode,
    input  wire logic [9:0]  s_number,
    input  wire logic [5:0]  s_led_index,
    input  wire logic        s_led_on,
    input  wire logic [1:0]  s_gun,
    output      logic        m_valid,
    input  wire logic        m_ready,
    output      logic [2:0]  m_row_drive,
    output      logic [7:0]  m_column_drive,
    output      logic        m_error_ground,
    output      logic        m_accepted
);
    import lmsd_pkg::*;

    // sequencer: idle -> (digits) -> read/modify rows -> fetch -> out, or idle -> fetch
    typedef enum logic [2:0] {
        ST_IDLE, ST_DIGITS, ST_READ, ST_MODIFY, ST_FETCH, ST_OUT
    } state_t;

    state_t     state_reg;
    logic [2:0] row_reg;
    mode_t      mode_reg;
    logic [5:0] led_index_reg;
    logic       led_on_reg;
    logic [1:0] gun_reg;
    logic [2:0] scan_row_reg;
    logic       error_reg;
    logic       acc_reg;
    logic [7:0] row_valid_reg;

    logic       m_valid_reg;
    logic [2:0] m_row_reg;
    logic [7:0] m_col_reg;
    logic       m_err_reg;
    logic       m_acc_reg;

    // frame buffer memory, one read and one write port, registered read
    logic [7:0] frame_mem [8];
    logic [7:0] rd_data_reg;
    logic       rd_valid_reg;
    logic [2:0] rd_addr;

    mode_t      in_mode;
    logic       in_ok;
    logic       need_digits;
    logic       dig_start;
    digits_t    dig_res;

    logic [7:0] old_row;
    logic [7:0] new_row;
    logic [3:0] digit_sel;
    logic [6:0] seg_bits;
    logic       gun_row;
    logic       gun_dot;
    logic [4:0] bar6;
    logic [4:0] bar7;

    // lowest n columns lit, capped at the five bar columns
    function automatic logic [4:0] bar_bits(input logic [3:0] n);
        logic [4:0] b;
        unique case (n)
            4'd0:    b = 5'h00;
            4'd1:    b = 5'h01;
            4'd2:    b = 5'h03;
            4'd3:    b = 5'h07;
            4'd4:    b = 5'h0F;
            default: b = BAR_FULL;
        endcase
        return b;
    endfunction

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_row_drive    = m_row_reg;
    assign m_column_drive = m_col_reg;
    assign m_error_ground = m_err_reg;
    assign m_accepted     = m_acc_reg;

    // range check on the incoming transaction
    always_comb begin
        in_mode = mode_t'(s_mode);
        unique case (in_mode)
            MODE_CHARGE, MODE_BAR: in_ok = (s_number <= CHARGE_MAX);
            MODE_ENERGY:           in_ok = (s_number <= ENERGY_MAX);
            default:               in_ok = 1'b1;
        endcase
        need_digits = in_ok && ((in_mode == MODE_CHARGE) || (in_mode == MODE_ENERGY)
                                || (in_mode == MODE_BAR));
    end

    assign dig_start = s_valid && s_ready && need_digits;

    // shared subtract unit splits the number into decimal digits
    lmsd_digit_split u_split (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dig_start),
        .value   (s_number),
        .res     (dig_res)
    );

    // row update: the old row comes back from the memory, rows never written read zero
    always_comb begin
        old_row = rd_valid_reg ? rd_data_reg : 8'h00;

        if (row_reg == 3'd0 || row_reg == 3'd3) begin
            digit_sel = dig_res.hund;
        end else if (row_reg == 3'd1 || row_reg == 3'd4) begin
            digit_sel = dig_res.tens;
        end else begin
            digit_sel = dig_res.ones;
        end
        seg_bits = seg_of(digit_sel);

        // gun dots only live on the charge digit rows
        gun_row = (row_reg[2] == 1'b0) && (row_reg[1:0] != 2'd3) && (gun_reg != GUN_NONE);
        gun_dot = (row_reg[1:0] == gun_reg);

        // bar from the digits: tens under 6 on the left bar, the rest spills right
        if (dig_res.hund != 4'd0) begin
            bar6 = BAR_FULL;
            bar7 = BAR_FULL;
        end else if (dig_res.tens < 4'd6) begin
            bar6 = bar_bits(dig_res.tens);
            bar7 = 5'h00;
        end else begin
            bar6 = BAR_FULL;
            bar7 = bar_bits(dig_res.tens - 4'd5);
        end

        new_row = old_row;
        unique case (mode_reg)
            MODE_CHARGE: begin
                if (row_reg <= 3'd2) new_row = {old_row[7], seg_bits};
            end
            MODE_ENERGY: begin
                if (row_reg == 3'd3) new_row = {old_row[7], seg_bits};
                if (row_reg == 3'd4 || row_reg == 3'd5) new_row = {1'b1, seg_bits};
            end
            MODE_GUN: begin
                if (gun_row) new_row = {gun_dot, old_row[6:0]};
            end
            MODE_LED: begin
                if (row_reg == led_index_reg[5:3]) begin
                    if (led_on_reg) new_row = old_row | (8'h01 << led_index_reg[2:0]);
                    else            new_row = old_row & ~(8'h01 << led_index_reg[2:0]);
                end
            end
            MODE_BAR: begin
                if (row_reg == 3'd6) new_row = old_row | {3'b000, bar6};
                if (row_reg == 3'd7) new_row = old_row | {3'b000, bar7};
            end
            MODE_CLEAR: new_row = 8'h00;
            MODE_ERROR: new_row = gun_row ? {gun_dot, 7'h00} : 8'h00;
            default:    new_row = old_row;
        endcase
    end

    // scan row stays addressed while the result waits, so a stall keeps the fetched row
    assign rd_addr = (state_reg == ST_FETCH || state_reg == ST_OUT) ? scan_row_reg : row_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MODIFY) begin
            frame_mem[row_reg] <= new_row;
        end
        rd_data_reg  <= frame_mem[rd_addr];
        rd_valid_reg <= row_valid_reg[rd_addr];
    end

    // sequencer, control state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_row_reg  <= 3'd0;
            error_reg     <= 1'b0;
            row_valid_reg <= 8'h00;
            m_valid_reg   <= 1'b0;
        end else begin
            // result taken downstream, unless a new one is loaded below
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        mode_reg      <= in_mode;
                        led_index_reg <= s_led_index;
                        led_on_reg    <= s_led_on;
                        gun_reg       <= s_gun;
                        acc_reg       <= in_ok;
                        row_reg       <= 3'd0;
                        if (in_mode == MODE_TICK) begin
                            scan_row_reg <= scan_row_reg + 3'd1;
                            state_reg    <= ST_FETCH;
                        end else if (!in_ok) begin
                            state_reg <= ST_FETCH;
                        end else begin
                            error_reg <= (in_mode == MODE_ERROR);
                            state_reg <= need_digits ? ST_DIGITS : ST_READ;
                        end
                    end
                end
                ST_DIGITS: begin
                    if (dig_res.done) state_reg <= ST_READ;
                end
                ST_READ: begin
                    state_reg <= ST_MODIFY;
                end
                ST_MODIFY: begin
                    row_valid_reg[row_reg] <= 1'b1;
                    if (row_reg == 3'd7) begin
                        state_reg <= ST_FETCH;
                    end else begin
                        row_reg   <= row_reg + 3'd1;
                        state_reg <= ST_READ;
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // wait for room in the result register
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_row_reg   <= scan_row_reg;
                        m_col_reg   <= rd_valid_reg ? rd_data_reg : 8'h00;
                        m_err_reg   <= error_reg;
                        m_acc_reg   <= acc_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lmsd_digit_split.sv =====
// iterative decimal split: hundreds, tens and ones by repeated subtraction
// depends on lmsd_pkg
`default_nettype none

module lmsd_digit_split (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [9:0]       value,
    output lmsd_pkg::digits_t     res
);
    import lmsd_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_HUND, ST_TENS} state_t;

    state_t      state_reg;
    logic [9:0]  rem_reg;
    logic [3:0]  hund_reg;
    logic [3:0]  tens_reg;
    logic [9:0]  step_k;
    logic [10:0] diff;
    logic        ge;

    // one shared subtractor, by 100 then by 10
    assign step_k = (state_reg == ST_HUND) ? 10'd100 : 10'd10;
    assign diff   = {1'b0, rem_reg} - {1'b0, step_k};
    assign ge     = ~diff[10];

    assign res.done = (state_reg == ST_TENS) && !ge;
    assign res.hund = hund_reg;
    assign res.tens = tens_reg;
    assign res.ones = rem_reg[3:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        rem_reg   <= value;
                        hund_reg  <= 4'd0;
                        tens_reg  <= 4'd0;
                        state_reg <= ST_HUND;
                    end
                end
                ST_HUND: begin
                    if (ge) begin
                        rem_reg  <= diff[9:0];
                        hund_reg <= hund_reg + 4'd1;
                    end else begin
                        state_reg <= ST_TENS;
                    end
                end
                ST_TENS: begin
                    if (ge) begin
                        rem_reg  <= diff[9:0];
                        tens_reg <= tens_reg + 4'd1;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lmsd_checker.sv =====
// port-level checks of the led matrix scan display, bound to the top level
// depends on led_matrix_scan_display_assert.svh and led_matrix_scan_display
`default_nettype none

`include "led_matrix_scan_display_assert.svh"

module lmsd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [2:0]  s_mode,
    input wire logic [9:0]  s_number,
    input wire logic [5:0]  s_led_index,
    input wire logic        s_led_on,
    input wire logic [1:0]  s_gun,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_row_drive,
    input wire logic [7:0]  m_column_drive,
    input wire logic        m_error_ground,
    input wire logic        m_accepted
);

    // a stalled result holds
    `LMSD_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_row_drive) && $stable(m_column_drive) && $stable(m_error_ground) && $stable(m_accepted), "result changed while stalled")

    // no result straight out of reset
    `LMSD_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !m_valid, "m_valid high after reset")

    // one transaction at a time: busy right after taking one
    `LMSD_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "input taken while busy")

    // a fresh result only comes from a busy sequencer
    `LMSD_ASSERT(a_result_from_work, aclk, aresetn, $rose(m_valid) |-> !$past(s_ready), "result without work")

endmodule

bind led_matrix_scan_display lmsd_checker u_lmsd_checker (.*);

`default_nettype wire

// ===== tb/led_matrix_scan_display_checker.sv =====
`timescale 1ns / 1ps
// checker for the led matrix scan display: predicts every result and compares it
// depends on lmsd_pkg for the command codes and the range limits

module led_matrix_scan_display_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [2:0]  s_mode,
    input  wire logic [9:0]  s_number,
    input  wire logic [5:0]  s_led_index,
    input  wire logic        s_led_on,
    input  wire logic [1:0]  s_gun,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [2:0]  m_row_drive,
    input  wire logic [7:0]  m_column_drive,
    input  wire logic        m_error_ground,
    input  wire logic        m_accepted,
    output int unsigned      fail_count,
    output int unsigned      pending
);
    import lmsd_pkg::*;

    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned BAR_SPLIT   = 60;
    localparam int unsigned BAR_OFFSET  = 50;
    // segment patterns for digits 0..9, digit d at bits d*7 +: 7
    localparam logic [69:0] SEG_GLYPHS = {
        7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };

    typedef struct packed {
        logic [2:0] row_drive;
        logic [7:0] column_drive;
        logic       error_ground;
        logic       accepted;
    } scan_result_t;

    logic [7:0]   frame_image [8];
    logic [2:0]   scan_row_q;
    logic         err_flag_q;
    scan_result_t expected_scan_q [$];
    int unsigned  mismatches = 0;

    function automatic void put_digits(int unsigned first_row, int unsigned value);
        int unsigned d [3];
        d[0] = value / 100;
        d[1] = (value / 10) % 10;
        d[2] = value % 10;
        for (int k = 0; k < 3; k++)
            frame_image[first_row + k] = {frame_image[first_row + k][7],
                                          SEG_GLYPHS[d[k] * 7 +: 7]};
    endfunction

    // gun code equals the row whose dot it lights
    function automatic void apply_gun(logic [1:0] gun);
        if (gun == GUN_NONE)
            return;
        for (int r = 0; r < 3; r++)
            frame_image[r][7] = (gun == r);
    endfunction

    function automatic logic [7:0] bar_mask(int unsigned n);
        if (n > 5)
            n = 5;
        return 8'((1 << n) - 1);
    endfunction

    function automatic void clear_frame();
        foreach (frame_image[r])
            frame_image[r] = '0;
    endfunction

    function automatic scan_result_t predict_scan_output(mode_t mode, logic [9:0] number,
            logic [5:0] led_index, logic led_on, logic [1:0] gun);
        scan_result_t res;
        res.accepted = 1'b1;
        case (mode)
            MODE_TICK: scan_row_q = scan_row_q + 3'd1;
            MODE_CHARGE: begin
                if (number > CHARGE_MAX) begin
                    res.accepted = 1'b0;
                end else begin
                    err_flag_q = 1'b0;
                    put_digits(0, number);
                end
            end
            MODE_ENERGY: begin
                if (number > ENERGY_MAX) begin
                    res.accepted = 1'b0;
                end else begin
                    err_flag_q = 1'b0;
                    put_digits(3, number);
                    frame_image[4][7] = 1'b1;
                    frame_image[5][7] = 1'b1;
                end
            end
            MODE_GUN: begin
                err_flag_q = 1'b0;
                apply_gun(gun);
            end
            MODE_LED: begin
                err_flag_q = 1'b0;
                frame_image[led_index[5:3]][led_index[2:0]] = led_on;
            end
            MODE_BAR: begin
                if (number > CHARGE_MAX) begin
                    res.accepted = 1'b0;
                end else begin
                    err_flag_q = 1'b0;
                    if (number < BAR_SPLIT) begin
                        frame_image[6] |= bar_mask(number / 10);
                    end else if (number < CHARGE_MAX) begin
                        frame_image[6] |= {3'b000, BAR_FULL};
                        frame_image[7] |= bar_mask((number - BAR_OFFSET) / 10);
                    end else begin
                        frame_image[6] |= {3'b000, BAR_FULL};
                        frame_image[7] |= {3'b000, BAR_FULL};
                    end
                end
            end
            MODE_CLEAR: begin
                clear_frame();
                err_flag_q = 1'b0;
            end
            default: begin
                clear_frame();
                apply_gun(gun);
                err_flag_q = 1'b1;
            end
        endcase
        res.row_drive    = scan_row_q;
        res.column_drive = frame_image[scan_row_q];
        res.error_ground = err_flag_q;
        return res;
    endfunction

    function automatic void report_mismatch(string what, scan_result_t want,
            scan_result_t seen);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected row %0d col %02h ground %0b accepted %0b, got row %0d col %02h ground %0b accepted %0b",
                     $time, what, want.row_drive, want.column_drive, want.error_ground,
                     want.accepted, seen.row_drive, seen.column_drive, seen.error_ground,
                     seen.accepted);
    endfunction

    always @(posedge aclk) begin
        scan_result_t want;
        scan_result_t seen;
        if (!aresetn) begin
            clear_frame();
            scan_row_q = '0;
            err_flag_q = 1'b0;
            expected_scan_q.delete();
        end else begin
            if (s_valid && s_ready)
                expected_scan_q.push_back(predict_scan_output(mode_t'(s_mode), s_number,
                                          s_led_index, s_led_on, s_gun));
            if (m_valid && m_ready) begin
                seen = {m_row_drive, m_column_drive, m_error_ground, m_accepted};
                if (expected_scan_q.size() == 0) begin
                    report_mismatch("result with no transaction outstanding", '0, seen);
                end else begin
                    want = expected_scan_q.pop_front();
                    if (seen.row_drive !== want.row_drive
                            || seen.column_drive !== want.column_drive
                            || seen.error_ground !== want.error_ground
                            || seen.accepted !== want.accepted)
                        report_mismatch("result mismatch", want, seen);
                end
            end
        end
        pending    <= expected_scan_q.size();
        fail_count <= mismatches;
    end

endmodule

// ===== tb/led_matrix_scan_display_tb.sv =====
`timescale 1ns / 1ps
// top of the led matrix scan display testbench: clock, reset, stimulus and verdict
// depends on lmsd_pkg, led_matrix_scan_display and led_matrix_scan_display_checker

module led_matrix_scan_display_tb;
    import lmsd_pkg::*;

    // gun codes for the directed part, none comes from the package
    localparam logic [1:0] GUN_A = 2'd0;
    localparam logic [1:0] GUN_B = 2'd1;
    localparam logic [1:0] GUN_C = 2'd2;

    localparam int unsigned RANDOM_PER_PHASE = 442;
    localparam int unsigned LONG_HOLD        = 400;  // receiver hold-off in cycles
    localparam int unsigned STALL_LIMIT      = 4000; // cycles with no transaction at all
    localparam int unsigned DRAIN_CYCLES     = 60;

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [2:0]  s_mode         = MODE_TICK;
    logic [9:0]  s_number       = '0;
    logic [5:0]  s_led_index    = '0;
    logic        s_led_on       = 1'b0;
    logic [1:0]  s_gun          = GUN_NONE;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [2:0]  m_row_drive;
    logic [7:0]  m_column_drive;
    logic        m_error_ground;
    logic        m_accepted;

    // idling percentages per phase, written at the clock edge
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    // each increment asks the receiver for one long hold-off
    int unsigned hold_requests  = 0;

    int unsigned fail_count;
    int unsigned pending;

    led_matrix_scan_display DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_number       (s_number),
        .s_led_index    (s_led_index),
        .s_led_on       (s_led_on),
        .s_gun          (s_gun),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_row_drive    (m_row_drive),
        .m_column_drive (m_column_drive),
        .m_error_ground (m_error_ground),
        .m_accepted     (m_accepted)
    );

    led_matrix_scan_display_checker scan_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_number       (s_number),
        .s_led_index    (s_led_index),
        .s_led_on       (s_led_on),
        .s_gun          (s_gun),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_row_drive    (m_row_drive),
        .m_column_drive (m_column_drive),
        .m_error_ground (m_error_ground),
        .m_accepted     (m_accepted),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // offer one command, with a random number of idle cycles first;
    // valid is only lowered while idling, so back-to-back transactions keep it high
    task automatic send_command(mode_t mode, logic [9:0] number, logic [5:0] led_index,
            logic led_on, logic [1:0] gun);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_number    <= number;
        s_led_index <= led_index;
        s_led_on    <= led_on;
        s_gun       <= gun;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // mostly ticks and in-range commands so the frame fills up and gets scanned,
    // with clear and error kept rarer so the picture is not wiped too often
    task automatic send_random_command();
        mode_t       mode;
        logic [9:0]  number;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 35) begin
            mode = MODE_TICK;
        end else begin
            mode = mode_t'($urandom_range(7, 1));
            if ((mode == MODE_CLEAR || mode == MODE_ERROR) && $urandom_range(1))
                mode = mode_t'($urandom_range(5, 1));
        end
        case (mode)
            MODE_CHARGE, MODE_BAR: begin
                if ($urandom_range(99) < 85)
                    number = 10'($urandom_range(CHARGE_MAX));
                else
                    number = 10'($urandom_range(1023));
            end
            MODE_ENERGY: begin
                if ($urandom_range(99) < 90)
                    number = 10'($urandom_range(ENERGY_MAX));
                else
                    number = 10'($urandom_range(1023, ENERGY_MAX + 1));
            end
            default: number = 10'($urandom_range(1023));
        endcase
        send_command(mode, number, 6'($urandom_range(63)), 1'($urandom_range(1)),
                     2'($urandom_range(3)));
    endtask

    // receiver: random ready, plus a long hold-off counted here on request
    initial begin : receiver
        int unsigned hold_left;
        int unsigned served;
        hold_left = 0;
        served    = 0;
        forever begin
            @(posedge aclk);
            if (hold_left == 0 && served != hold_requests) begin
                served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog: too long without any transaction on either channel
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("led_matrix_scan_display verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned n;
        send_idle_pct <= 16;
        recv_idle_pct <= 85;
        // synchronous reset held at the start, then released
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: charge digits at both ends and out of range
        send_command(MODE_CHARGE, 10'd0, 6'd0, 1'b0, GUN_NONE);
        send_command(MODE_CHARGE, CHARGE_MAX, 6'd0, 1'b0, GUN_NONE);
        send_command(MODE_CHARGE, CHARGE_MAX + 10'd1, 6'd0, 1'b0, GUN_NONE);
        send_command(MODE_CHARGE, 10'h3FF, 6'h3F, 1'b1, GUN_A);
        // a tick, then energy digits: top value, just above it, all ones
        send_command(MODE_TICK, 10'd0, 6'd0, 1'b0, GUN_NONE);
        send_command(MODE_ENERGY, ENERGY_MAX, 6'd0, 1'b0, GUN_NONE);
        send_command(MODE_ENERGY, ENERGY_MAX + 10'd1, 6'd0, 1'b0, GUN_NONE);
        send_command(MODE_ENERGY, 10'h3FF, 6'd0, 1'b0, GUN_NONE);
        // gun dots for every code, none leaves them alone
        send_command(MODE_GUN, 10'd0, 6'd0, 1'b0, GUN_A);
        send_command(MODE_GUN, 10'd0, 6'd0, 1'b0, GUN_B);
        send_command(MODE_GUN, 10'd0, 6'd0, 1'b0, GUN_C);
        send_command(MODE_GUN, 10'd0, 6'd0, 1'b0, GUN_NONE);
        // single leds at the corners set, the last one then cleared
        send_command(MODE_LED, 10'd0, 6'd0, 1'b1, GUN_NONE);
        send_command(MODE_LED, 10'd0, 6'h3F, 1'b1, GUN_NONE);
        send_command(MODE_LED, 10'd0, 6'h3F, 1'b0, GUN_NONE);
        // error with a gun, then a tick to see the flag held
        send_command(MODE_ERROR, 10'd0, 6'd0, 1'b0, GUN_C);
        send_command(MODE_TICK, 10'd0, 6'd0, 1'b0, GUN_NONE);
        // ring bar: low range, boundary, upper range, full, out of range
        send_command(MODE_BAR, 10'd59, 6'd0, 1'b0, GUN_NONE);
        send_command(MODE_BAR, 10'd60, 6'd0, 1'b0, GUN_NONE);
        send_command(MODE_BAR, 10'd99, 6'd0, 1'b0, GUN_NONE);
        send_command(MODE_BAR, CHARGE_MAX, 6'd0, 1'b0, GUN_NONE);
        send_command(MODE_BAR, CHARGE_MAX + 10'd1, 6'd0, 1'b0, GUN_NONE);
        // error with no gun, then clear drops the flag
        send_command(MODE_ERROR, 10'd0, 6'd0, 1'b0, GUN_NONE);
        send_command(MODE_CLEAR, 10'd0, 6'd0, 1'b0, GUN_NONE);
        send_command(MODE_TICK, 10'd0, 6'd0, 1'b0, GUN_NONE);

        // phase one: sender mostly busy, receiver mostly idle, with one long hold-off
        for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n == RANDOM_PER_PHASE / 2)
                hold_requests <= hold_requests + 1;
            send_random_command();
        end

        // phase two: the other way round
        send_idle_pct <= 85;
        recv_idle_pct <= 16;
        for (n = 0; n < RANDOM_PER_PHASE; n++)
            send_random_command();

        // phase three: no idling on either side
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        for (n = 0; n < RANDOM_PER_PHASE; n++)
            send_random_command();
        s_valid <= 1'b0;

        // drain outstanding results, then let the block settle
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending == 0)
            $display("led_matrix_scan_display verification clean");
        else
            $display("led_matrix_scan_display verification failed");
        $finish;
    end

endmodule
